>>> src/fifo_with_max_promotion_assert.svh
// Assertion macros used by the checker module of the max-promotion FIFO.
`ifndef FIFO_WITH_MAX_PROMOTION_ASSERT_SVH
`define FIFO_WITH_MAX_PROMOTION_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define FMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fmp assertion failed (same cycle)");

// Next-cycle implication, ignored while reset is asserted
`define FMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fmp assertion failed (next cycle)");

`endif

>>> src/fmp_pkg.sv
// Types and codes shared by the max-promotion FIFO modules.
package fmp_pkg;

    // Command opcodes
    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ     = 2'd1,
        OP_PROMOTE = 2'd2,
        OP_SEARCH  = 2'd3
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command transaction payload
    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] key_value;
    } t_cmd;

    // Result transaction payload
    typedef struct packed {
        t_status            status;
        logic signed [31:0] data_out;
        logic               found;
        logic [3:0]         position;
        logic [4:0]         occupancy;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    enq;
        logic    deq_rd;
        logic    deq_pop;
        logic    scan_rd;
        logic    shift_init;
        logic    shift_rd;
        logic    place;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_opcode op;
        logic    empty;
        logic    full;
        logic    scan_last;
        logic    shift_last;
        logic    at_zero;
    } t_dp_sts;

endpackage

>>> src/fmp_datapath.sv
// Datapath: entry store, head/count pointers, scan compare and shift pipeline.
module fmp_datapath #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fmp_pkg::t_cmd     i_cmd,
    input  fmp_pkg::t_dp_cmd  i_dp_cmd,
    output fmp_pkg::t_dp_sts  o_dp_sts,
    output logic              o_done,
    output fmp_pkg::t_result  o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Circular store
    logic signed [31:0] mem [DEPTH];

    logic [IW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    fmp_pkg::t_opcode   r_op;
    logic signed [31:0] r_key;
    logic signed [31:0] r_data;
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_best;
    logic [IW-1:0]      r_at;
    logic               r_found;
    logic [IW-1:0]      r_pos;
    logic [CW-1:0]      r_idx;
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_off;
    logic               r_wr_vld;
    logic [IW-1:0]      r_wr_off;
    logic               r_done;
    fmp_pkg::t_result   r_res;

    logic               rd_en;
    logic [CW-1:0]      rd_off;
    logic [IW-1:0]      rd_slot;
    logic               wr_en;
    logic [CW-1:0]      wr_off;
    logic [IW-1:0]      wr_slot;
    logic signed [31:0] wr_data;

    // Offset from head to physical slot; sum stays below twice DEPTH
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return IW'(sum);
    endfunction

    // Read port select
    always_comb begin
        rd_en  = i_dp_cmd.deq_rd | i_dp_cmd.scan_rd | i_dp_cmd.shift_rd;
        rd_off = '0;
        if (i_dp_cmd.scan_rd) begin
            rd_off = r_idx;
        end else if (i_dp_cmd.shift_rd) begin
            rd_off = r_idx - CW'(1);
        end
        rd_slot = slot_of(r_head, rd_off);
    end

    // Write port select: enqueue, pending shift write, or final placement
    always_comb begin
        wr_en   = i_dp_cmd.enq | r_wr_vld | i_dp_cmd.place;
        wr_off  = '0;
        wr_data = r_best;
        if (i_dp_cmd.enq) begin
            wr_off  = r_count;
            wr_data = r_key;
        end else if (r_wr_vld) begin
            wr_off  = CW'(r_wr_off);
            wr_data = r_rd_data;
        end
        wr_slot = slot_of(r_head, wr_off);
    end

    // Memory with registered read data
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_slot] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_slot];
        end
    end

    // Control state: pointers, pipeline tags, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_cmp_vld <= i_dp_cmd.scan_rd;
            r_wr_vld  <= i_dp_cmd.shift_rd;
            r_done    <= i_dp_cmd.finish;
            if (i_dp_cmd.enq) begin
                r_count <= r_count + CW'(1);
            end
            if (i_dp_cmd.deq_pop) begin
                r_count <= r_count - CW'(1);
                if (r_head == IW'(DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + IW'(1);
                end
            end
        end
    end

    // Payload: command capture, scan compare, shift index, result
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_op    <= i_cmd.opcode;
            r_key   <= i_cmd.key_value;
            r_data  <= '0;
            r_found <= 1'b0;
            r_pos   <= '0;
            r_idx   <= '0;
        end
        if (i_dp_cmd.deq_pop) begin
            r_data <= r_rd_data;
        end
        if (i_dp_cmd.scan_rd) begin
            r_idx     <= r_idx + CW'(1);
            r_cmp_off <= IW'(r_idx);
        end
        if (i_dp_cmd.shift_init) begin
            r_idx <= CW'(r_at);
        end
        if (i_dp_cmd.shift_rd) begin
            r_idx    <= r_idx - CW'(1);
            r_wr_off <= IW'(r_idx);
        end
        // one entry compared per cycle, in front-to-back order
        if (r_cmp_vld) begin
            if (r_op == fmp_pkg::OP_SEARCH) begin
                if (r_rd_data == r_key) begin
                    r_found <= 1'b1;
                    r_pos   <= r_cmp_off;
                end
            end else if (r_cmp_off == '0 || r_rd_data > r_best) begin
                r_best <= r_rd_data;
                r_at   <= r_cmp_off;
            end
        end
        if (i_dp_cmd.finish) begin
            r_res.status    <= i_dp_cmd.status;
            r_res.data_out  <= r_data;
            r_res.found     <= r_found;
            r_res.position  <= 4'(r_pos);
            r_res.occupancy <= 5'(r_count);
        end
    end

    // Status to controller
    always_comb begin
        o_dp_sts.op         = r_op;
        o_dp_sts.empty      = (r_count == '0);
        o_dp_sts.full       = (r_count == CW'(DEPTH));
        o_dp_sts.scan_last  = (r_idx == r_count - CW'(1));
        o_dp_sts.shift_last = (r_idx == CW'(1));
        o_dp_sts.at_zero    = (r_at == '0);
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> src/fmp_ctrl.sv
// Controller: sequences each command from decode through the dequeue, scan, shift and place steps it needs, to finish.
module fmp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fmp_pkg::t_dp_sts  i_dp_sts,
    output logic              o_busy,
    output fmp_pkg::t_dp_cmd  o_dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DEQ_WAIT,
        S_SCAN,
        S_SCAN_DRAIN,
        S_SHIFT_SETUP,
        S_SHIFT,
        S_SHIFT_DRAIN,
        S_PLACE,
        S_FINISH
    } t_state;

    t_state           r_state;
    t_state           n_state;
    fmp_pkg::t_status r_status;
    fmp_pkg::t_status n_status;

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_dp_cmd = '0;
        o_dp_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.load = 1'b1;
                    n_status      = fmp_pkg::ST_OK;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_dp_sts.op)
                    fmp_pkg::OP_ENQ: begin
                        if (i_dp_sts.full) begin
                            n_status = fmp_pkg::ST_FULL;
                        end else begin
                            o_dp_cmd.enq = 1'b1;
                        end
                        n_state = S_FINISH;
                    end
                    fmp_pkg::OP_DEQ: begin
                        if (i_dp_sts.empty) begin
                            n_status = fmp_pkg::ST_EMPTY;
                            n_state  = S_FINISH;
                        end else begin
                            o_dp_cmd.deq_rd = 1'b1;
                            n_state         = S_DEQ_WAIT;
                        end
                    end
                    fmp_pkg::OP_PROMOTE: begin
                        if (i_dp_sts.empty) begin
                            n_status = fmp_pkg::ST_EMPTY;
                            n_state  = S_FINISH;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        // search on an empty queue reports not found
                        n_state = i_dp_sts.empty ? S_FINISH : S_SCAN;
                    end
                endcase
            end
            S_DEQ_WAIT: begin
                o_dp_cmd.deq_pop = 1'b1;
                n_state          = S_FINISH;
            end
            S_SCAN: begin
                o_dp_cmd.scan_rd = 1'b1;
                if (i_dp_sts.scan_last) begin
                    n_state = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN: begin
                n_state = (i_dp_sts.op == fmp_pkg::OP_PROMOTE) ? S_SHIFT_SETUP : S_FINISH;
            end
            S_SHIFT_SETUP: begin
                // largest key already at the head: order stays
                o_dp_cmd.shift_init = 1'b1;
                n_state = i_dp_sts.at_zero ? S_FINISH : S_SHIFT;
            end
            S_SHIFT: begin
                o_dp_cmd.shift_rd = 1'b1;
                if (i_dp_sts.shift_last) begin
                    n_state = S_SHIFT_DRAIN;
                end
            end
            S_SHIFT_DRAIN: begin
                n_state = S_PLACE;
            end
            S_PLACE: begin
                o_dp_cmd.place = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                o_dp_cmd.finish = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= fmp_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> src/fifo_with_max_promotion.sv
// Top level of the bounded FIFO with search and promotion of the largest key.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------
//  command   | start high, busy low   | i_cmd    (opcode, key_value)
//  result    | o_done, one cycle      | o_result (status, data_out,
//            |                        |   found, position, occupancy)
//
// One command at a time. After acceptance, enqueue, errors and empty-queue search go
// to finish; dequeue reads and pops; other searches scan the queue; promotion scans,
// then, if the largest key is not first, moves those before it back and puts it first.
// One read and one write port: scan and shift each move one entry per cycle.
// Synchronous active-low reset empties the queue; store contents are not cleared.
// The receiver cannot stall; busy stays high until the result cycle.
module fifo_with_max_promotion #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fmp_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output fmp_pkg::t_result o_result
);

    fmp_pkg::t_dp_cmd dp_cmd;
    fmp_pkg::t_dp_sts dp_sts;

    // Command sequencer
    fmp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_dp_sts (dp_sts),
        .o_busy   (busy),
        .o_dp_cmd (dp_cmd)
    );

    // Store and arithmetic
    fmp_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_dp_cmd (dp_cmd),
        .o_dp_sts (dp_sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

>>> src/fmp_checker.sv
// Port-level checker for the max-promotion FIFO and its bind.
`include "fifo_with_max_promotion_assert.svh"

module fmp_checker #(
    parameter int DEPTH = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input fmp_pkg::t_result o_result
);

    logic accepted;
    assign accepted = start && !busy;

    // An accepted transaction occupies the block and never yields an instant result
    `FMP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accepted, busy && !o_done)

    // Result strobe only when the block has gone idle
    `FMP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)

    // A full rejection reports a full queue
    `FMP_ASSERT_NOW(a_full_occ, i_clk, i_rst_n,
        o_done && o_result.status == fmp_pkg::ST_FULL,
        o_result.occupancy == 5'(DEPTH))

    // An empty error reports an empty queue and no data
    `FMP_ASSERT_NOW(a_empty_res, i_clk, i_rst_n,
        o_done && o_result.status == fmp_pkg::ST_EMPTY,
        o_result.occupancy == 5'd0 && o_result.data_out == 32'sd0 && !o_result.found)

    // Search misses report position zero
    `FMP_ASSERT_NOW(a_miss_pos, i_clk, i_rst_n,
        o_done && !o_result.found, o_result.position == 4'd0)

endmodule

bind fifo_with_max_promotion fmp_checker #(
    .DEPTH (DEPTH)
) u_fmp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
